@@ design/tsc_pkg.sv @@
// Shared constants, types and helper functions for the touch sample calibrate filter.
package tsc_pkg;

    // Screen geometry and derived limits.
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int WMAX          = SCREEN_WIDTH - 1;
    localparam int HMAX          = SCREEN_HEIGHT - 1;
    localparam int SX_W          = $clog2(SCREEN_WIDTH);
    localparam int SY_W          = $clog2(SCREEN_HEIGHT);
    localparam int TOP_MAX       = (WMAX > HMAX) ? WMAX : HMAX;
    localparam int TOP_W         = $clog2(TOP_MAX + 1);

    // Field widths of the ports.
    localparam int SAMPLE_W   = 12;
    localparam int PRESS_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int OUT_SX_W   = 9;
    localparam int OUT_SY_W   = 8;

    // Divider operand widths: |raw - min| * top over |max - min|.
    localparam int NUM_W = SAMPLE_W + TOP_W;
    localparam int DEN_W = SAMPLE_W;

    localparam logic [SAMPLE_W-1:0] ADC_FULL = SAMPLE_W'(4095);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAW_MIN_X   = 3'd0,
        REG_RAW_MAX_X   = 3'd1,
        REG_RAW_MIN_Y   = 3'd2,
        REG_RAW_MAX_Y   = 3'd3,
        REG_SWAP_AXES   = 3'd4,
        REG_INVERT_H    = 3'd5,
        REG_INVERT_V    = 3'd6,
        REG_PRESS_THR   = 3'd7
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } seq_state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    // Status back from the shared divider.
    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_status_t;

    // Absolute difference of two samples.
    function automatic logic [SAMPLE_W-1:0] abs_diff(
        input logic [SAMPLE_W-1:0] p,
        input logic [SAMPLE_W-1:0] q
    );
        return (p > q) ? (p - q) : (q - p);
    endfunction

    // Truncated mean of the two closest samples; ties favor a|b, then a|c.
    function automatic logic [SAMPLE_W-1:0] closest_pair_mean(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] c
    );
        logic [SAMPLE_W-1:0] dab;
        logic [SAMPLE_W-1:0] dac;
        logic [SAMPLE_W-1:0] dbc;
        logic [SAMPLE_W:0]   sum;
        dab = abs_diff(a, b);
        dac = abs_diff(a, c);
        dbc = abs_diff(b, c);
        if (dab <= dac && dab <= dbc)
        begin
            sum = {1'b0, a} + {1'b0, b};
        end
        else if (dac <= dab && dac <= dbc)
        begin
            sum = {1'b0, a} + {1'b0, c};
        end
        else
        begin
            sum = {1'b0, b} + {1'b0, c};
        end
        return sum[SAMPLE_W:1];
    endfunction

endpackage

@@ design/tsc_div.sv @@
// Restoring unsigned divider that produces one quotient bit per cycle.
module tsc_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsc_pkg::div_req_t    req,
    output tsc_pkg::div_status_t status
);
    import tsc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W+1:0] trial;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[DEN_W+1])
            begin
                rem_next = rem_shift[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (req.start)
        begin
            dvs_reg <= req.divisor;
        end
    end

    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

@@ design/touch_sample_calibrate_filter.sv @@
// A touch item is captured, mapped on each axis in turn (ST_MUL, then ST_DIV through the divider),
// then filtered and presented in ST_DONE; an empty calibrated span skips the divider for that axis.
// The shared restoring divider produces one quotient bit per cycle per axis.
// A no-touch item goes from capture straight to ST_DONE; no new item is taken until the result loads.
// Reset (rst_n low, asynchronous) loads the default calibration and clears the filter
// and the pressed flag; no clearing pass follows.
module touch_sample_calibrate_filter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             bus_ok,
    input  logic [tsc_pkg::SAMPLE_W-1:0]     pressure_first,
    input  logic [tsc_pkg::SAMPLE_W-1:0]     pressure_second,
    input  logic [tsc_pkg::SAMPLE_W-1:0]     x_sample_0,
    input  logic [tsc_pkg::SAMPLE_W-1:0]     x_sample_1,
    input  logic [tsc_pkg::SAMPLE_W-1:0]     x_sample_2,
    input  logic [tsc_pkg::SAMPLE_W-1:0]     y_sample_0,
    input  logic [tsc_pkg::SAMPLE_W-1:0]     y_sample_1,
    input  logic [tsc_pkg::SAMPLE_W-1:0]     y_sample_2,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             touched,
    output logic [tsc_pkg::SAMPLE_W-1:0]     raw_x,
    output logic [tsc_pkg::SAMPLE_W-1:0]     raw_y,
    output logic [tsc_pkg::OUT_SX_W-1:0]     screen_x,
    output logic [tsc_pkg::OUT_SY_W-1:0]     screen_y
);
    import tsc_pkg::*;

    // Calibration registers.
    logic [SAMPLE_W-1:0] raw_min_x_reg;
    logic [SAMPLE_W-1:0] raw_max_x_reg;
    logic [SAMPLE_W-1:0] raw_min_y_reg;
    logic [SAMPLE_W-1:0] raw_max_y_reg;
    logic                swap_axes_reg;
    logic                invert_h_reg;
    logic                invert_v_reg;
    logic [PRESS_W-1:0]  press_thr_reg;

    // Sequencer and item state.
    seq_state_t          state_reg;
    seq_state_t          state_next;
    logic                axis_reg;
    logic                axis_next;
    logic                touch_reg;
    logic                touch_next;
    logic [SAMPLE_W-1:0] rx_reg;
    logic [SAMPLE_W-1:0] rx_next;
    logic [SAMPLE_W-1:0] ry_reg;
    logic [SAMPLE_W-1:0] ry_next;
    logic                neg_reg;
    logic                neg_next;
    logic [SX_W-1:0]     map_x_reg;
    logic [SX_W-1:0]     map_x_next;
    logic [SY_W-1:0]     map_y_reg;
    logic [SY_W-1:0]     map_y_next;

    // Filter state.
    logic                was_pressed_reg;
    logic                was_pressed_next;
    logic [SX_W-1:0]     filt_x_reg;
    logic [SX_W-1:0]     filt_x_next;
    logic [SY_W-1:0]     filt_y_reg;
    logic [SY_W-1:0]     filt_y_next;

    // Output register.
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                touched_reg;
    logic [SAMPLE_W-1:0] raw_x_reg;
    logic [SAMPLE_W-1:0] raw_y_reg;
    logic [OUT_SX_W-1:0] screen_x_reg;
    logic [OUT_SY_W-1:0] screen_y_reg;
    logic                out_load;

    // Datapath signals.
    logic                in_accept;
    logic [PRESS_W-1:0]  pressure;
    logic [SAMPLE_W-1:0] x_mean;
    logic [SAMPLE_W-1:0] y_mean;
    logic [SAMPLE_W-1:0] src;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [TOP_W-1:0]    top;
    logic                invert;
    logic                span_empty;
    logic [SAMPLE_W-1:0] diff_mag;
    logic [DEN_W-1:0]    den_mag;
    logic [NUM_W-1:0]    product;
    logic [TOP_W-1:0]    q_clamped;
    logic [TOP_W-1:0]    q_base;
    logic [TOP_W-1:0]    axis_result;
    logic [SX_W+1:0]     sum_x;
    logic [SY_W+1:0]     sum_y;
    logic [SX_W-1:0]     iir_x;
    logic [SY_W-1:0]     iir_y;

    div_req_t            div_req;
    div_status_t         div_status;

    tsc_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (div_req),
        .status (div_status)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Pressure check and closest-pair averaging of the incoming sample set.
    assign pressure = {1'b0, pressure_first} + {1'b0, ADC_FULL} - {1'b0, pressure_second};
    assign x_mean   = closest_pair_mean(x_sample_0, x_sample_1, x_sample_2);
    assign y_mean   = closest_pair_mean(y_sample_0, y_sample_1, y_sample_2);

    // Operands of the axis now being mapped.
    always_comb
    begin
        if (axis_reg)
        begin
            src    = swap_axes_reg ? rx_reg : ry_reg;
            lo     = raw_min_y_reg;
            hi     = raw_max_y_reg;
            top    = TOP_W'(HMAX);
            invert = invert_v_reg;
        end
        else
        begin
            src    = swap_axes_reg ? ry_reg : rx_reg;
            lo     = raw_min_x_reg;
            hi     = raw_max_x_reg;
            top    = TOP_W'(WMAX);
            invert = invert_h_reg;
        end
        span_empty = (lo == hi);
        diff_mag   = (src >= lo) ? (src - lo) : (lo - src);
        den_mag    = (hi >= lo) ? (hi - lo) : (lo - hi);
        product    = NUM_W'(diff_mag) * NUM_W'(top);
    end

    // A negative quotient clamps to zero, a large one to the last pixel.
    always_comb
    begin
        if (neg_reg)
        begin
            q_clamped = '0;
        end
        else if (div_status.quotient > NUM_W'(top))
        begin
            q_clamped = top;
        end
        else
        begin
            q_clamped = div_status.quotient[TOP_W-1:0];
        end
        q_base      = (state_reg == ST_MUL) ? '0 : q_clamped;
        axis_result = invert ? (top - q_base) : q_base;
    end

    // Three-quarter IIR smoothing; all terms are non-negative, so a shift truncates.
    assign sum_x = ({2'b00, filt_x_reg} << 1) + {2'b00, filt_x_reg} + {2'b00, map_x_reg};
    assign sum_y = ({2'b00, filt_y_reg} << 1) + {2'b00, filt_y_reg} + {2'b00, map_y_reg};
    assign iir_x = was_pressed_reg ? sum_x[SX_W+1:2] : map_x_reg;
    assign iir_y = was_pressed_reg ? sum_y[SY_W+1:2] : map_y_reg;

    // Sequencer: capture, map each axis through the divider, then filter and present.
    always_comb
    begin
        state_next       = state_reg;
        axis_next        = axis_reg;
        touch_next       = touch_reg;
        rx_next          = rx_reg;
        ry_next          = ry_reg;
        neg_next         = neg_reg;
        map_x_next       = map_x_reg;
        map_y_next       = map_y_reg;
        was_pressed_next = was_pressed_reg;
        filt_x_next      = filt_x_reg;
        filt_y_next      = filt_y_reg;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = product;
        div_req.divisor  = den_mag;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    touch_next = bus_ok && (pressure >= press_thr_reg);
                    rx_next    = y_mean;
                    ry_next    = ADC_FULL - x_mean;
                    axis_next  = 1'b0;
                    state_next = (bus_ok && (pressure >= press_thr_reg)) ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL:
            begin
                neg_next = (src < lo) ^ (hi < lo);
                if (span_empty)
                begin
                    // An empty span maps to zero before the mirror.
                    if (axis_reg)
                    begin
                        map_y_next = SY_W'(axis_result);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        map_x_next = SX_W'(axis_result);
                        axis_next  = 1'b1;
                    end
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    if (axis_reg)
                    begin
                        map_y_next = SY_W'(axis_result);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        map_x_next = SX_W'(axis_result);
                        axis_next  = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (touch_reg)
                    begin
                        was_pressed_next = 1'b1;
                        filt_x_next      = iir_x;
                        filt_y_next      = iir_y;
                    end
                    else
                    begin
                        was_pressed_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    // Control, calibration and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            axis_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            was_pressed_reg <= 1'b0;
            filt_x_reg      <= '0;
            filt_y_reg      <= '0;
            raw_min_x_reg   <= SAMPLE_W'(200);
            raw_max_x_reg   <= SAMPLE_W'(3700);
            raw_min_y_reg   <= SAMPLE_W'(200);
            raw_max_y_reg   <= SAMPLE_W'(3700);
            swap_axes_reg   <= 1'b1;
            invert_h_reg    <= 1'b0;
            invert_v_reg    <= 1'b0;
            press_thr_reg   <= PRESS_W'(180);
        end
        else
        begin
            state_reg       <= state_next;
            axis_reg        <= axis_next;
            out_valid_reg   <= out_valid_next;
            was_pressed_reg <= was_pressed_next;
            filt_x_reg      <= filt_x_next;
            filt_y_reg      <= filt_y_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RAW_MIN_X: raw_min_x_reg <= cfg_data[SAMPLE_W-1:0];
                    REG_RAW_MAX_X: raw_max_x_reg <= cfg_data[SAMPLE_W-1:0];
                    REG_RAW_MIN_Y: raw_min_y_reg <= cfg_data[SAMPLE_W-1:0];
                    REG_RAW_MAX_Y: raw_max_y_reg <= cfg_data[SAMPLE_W-1:0];
                    REG_SWAP_AXES: swap_axes_reg <= cfg_data[0];
                    REG_INVERT_H:  invert_h_reg  <= cfg_data[0];
                    REG_INVERT_V:  invert_v_reg  <= cfg_data[0];
                    REG_PRESS_THR: press_thr_reg <= cfg_data[PRESS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Item payload and output payload.
    always_ff @(posedge clk)
    begin
        touch_reg <= touch_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        neg_reg   <= neg_next;
        map_x_reg <= map_x_next;
        map_y_reg <= map_y_next;
        if (out_load)
        begin
            touched_reg <= touch_reg;
            if (touch_reg)
            begin
                raw_x_reg    <= rx_reg;
                raw_y_reg    <= ry_reg;
                screen_x_reg <= OUT_SX_W'(iir_x);
                screen_y_reg <= OUT_SY_W'(iir_y);
            end
            else
            begin
                raw_x_reg    <= '0;
                raw_y_reg    <= '0;
                screen_x_reg <= '0;
                screen_y_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign touched   = touched_reg;
    assign raw_x     = raw_x_reg;
    assign raw_y     = raw_y_reg;
    assign screen_x  = screen_x_reg;
    assign screen_y  = screen_y_reg;

endmodule

@@ design/tsc_checker.sv @@
// Port-level assertions for the touch sample calibrate filter, bound to the top level.
module tsc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           touched,
    input logic [tsc_pkg::SAMPLE_W-1:0]   raw_x,
    input logic [tsc_pkg::SAMPLE_W-1:0]   raw_y,
    input logic [tsc_pkg::OUT_SX_W-1:0]   screen_x,
    input logic [tsc_pkg::OUT_SY_W-1:0]   screen_y
);
    import tsc_pkg::*;

    // A held result keeps its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(touched) && $stable(raw_x)
            && $stable(raw_y) && $stable(screen_x) && $stable(screen_y))
    else $error("stalled result changed");

    // An accepted item keeps the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an item");

    // No result appears in the cycle right after an item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

    // A no-touch result carries all-zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !touched |-> raw_x == '0 && raw_y == '0
            && screen_x == '0 && screen_y == '0)
    else $error("no-touch result has nonzero fields");

    // Screen coordinates stay on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && touched |-> screen_x <= OUT_SX_W'(WMAX) && screen_y <= OUT_SY_W'(HMAX))
    else $error("screen coordinate off the screen");

endmodule

bind touch_sample_calibrate_filter tsc_checker u_tsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .touched   (touched),
    .raw_x     (raw_x),
    .raw_y     (raw_y),
    .screen_x  (screen_x),
    .screen_y  (screen_y)
);
